### rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// overlapping implication, disabled while reset is high
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also holds across reset
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/fjss_pkg.sv
// types and constants of the feeder jam and shot sequencer
// no dependencies; imported by every module of the block
package fjss_pkg;

   // shooter modes
   localparam logic [1:0] MODE_SLEEP  = 2'd0;
   localparam logic [1:0] MODE_REMOTE = 2'd1;
   localparam logic [1:0] MODE_VISION = 2'd2;
   localparam logic [1:0] MODE_DEBUG  = 2'd3;

   // friction wheel selects
   localparam logic [1:0] FRIC_OFF  = 2'd0;
   localparam logic [1:0] FRIC_HIGH = 2'd1;
   localparam logic [1:0] FRIC_TEST = 2'd2;

   // register indexes
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHOT_INCREMENT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHOT_INTERVAL  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE_DELAY     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STALL_SPEED    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_STALL_CURRENT  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_STALL_TICKS    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_PITCH_WINDOW   = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_YAW_WINDOW     = 3'd7;

   // divide by ten: x / 10 == (x * 838861) >> 23 for any x below 2^22
   localparam int          TENTH_W     = 17;
   localparam int          TENTH_SHIFT = 23;
   localparam logic [23:0] TENTH_RECIP = 24'd838861;

   // stream widths
   localparam int REQ_TDATA_W = 136;
   localparam int RSP_TDATA_W = 40;

   // configuration seen by the datapath
   typedef struct packed {
      logic [19:0]        shot_increment;
      logic [TENTH_W-1:0] shot_tenth;
      logic [15:0]        shot_interval;
      logic [15:0]        mode_delay;
      logic [14:0]        stall_speed;
      logic [14:0]        stall_current;
      logic [14:0]        stall_ticks;
      logic [15:0]        pitch_window;
      logic [15:0]        yaw_window;
   } cfg_type;

   // one input transaction
   typedef struct packed {
      logic [1:0]         mode;
      logic signed [15:0] motor_speed;
      logic signed [15:0] motor_current;
      logic signed [31:0] feeder_angle;
      logic               target_locked;
      logic signed [15:0] pitch_target;
      logic signed [15:0] pitch_measured;
      logic signed [15:0] yaw_target;
      logic signed [15:0] yaw_measured;
   } req_item_type;

   // one result transaction
   typedef struct packed {
      logic signed [31:0] feed_setpoint;
      logic               loop_active;
      logic               drive_enable;
      logic               fixed_limit;
      logic               aim_ok;
      logic               jammed;
      logic [1:0]         friction_select;
   } rsp_item_type;

endpackage

### rtl/feeder_jam_and_shot_sequencer.sv
// feeder jam detector and shot sequencer, top level
// depends on fjss_pkg, fjss_csr and fjss_core
//
// Usage: one req transaction per 1 ms control tick carries the shooter
// mode, feeder motor speed and current, feeder angle and the vision and
// gimbal angles; exactly one rsp transaction follows per tick with the
// feeder position setpoint, the loop, drive and clamp selects, the aim and
// jam flags and the friction wheel select.
// The accepting req edge loads the input register; the result register
// then loads the tick update once the output is free to advance.
// Throughput, unless rsp_tready stalls, is one tick per cycle; the tick
// update is a single pass of compare and add logic against the block state.
// When rsp_tready is low the result register holds and the input register
// still takes one more tick; req_tready drops only when both are full.
// The csr port writes the tuning registers; write it only when
// no tick is in flight.
// Reset clears the state and the pipeline and reloads the default tuning.
module feeder_jam_and_shot_sequencer
   import fjss_pkg::*;
#(
   parameter int ANGLE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   // mode[1:0], motor_speed[17:2], motor_current[33:18], feeder_angle[65:34],
   // target_locked[66], pitch_target[82:67], pitch_measured[98:83],
   // yaw_target[114:99], yaw_measured[130:115], zero fill above
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // feed_setpoint[31:0], loop_active[32], drive_enable[33], fixed_limit[34],
   // aim_ok[35], jammed[36], friction_select[38:37], zero fill above
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type      cfg;
   req_item_type req_item, in_item_ff;
   rsp_item_type result, out_item_ff;
   logic         in_valid_ff, in_valid_in;
   logic         out_valid_ff, out_valid_in;
   logic         advance, load, step;

   fjss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // unpack the request transaction
   always_comb begin
      req_item.mode           = req_tdata[1:0];
      req_item.motor_speed    = req_tdata[17:2];
      req_item.motor_current  = req_tdata[33:18];
      req_item.feeder_angle   = req_tdata[65:34];
      req_item.target_locked  = req_tdata[66];
      req_item.pitch_target   = req_tdata[82:67];
      req_item.pitch_measured = req_tdata[98:83];
      req_item.yaw_target     = req_tdata[114:99];
      req_item.yaw_measured   = req_tdata[130:115];
   end

   // pipeline handshake
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign load       = req_tvalid && req_tready;
   assign step       = in_valid_ff && advance;

   always_comb begin
      if (load) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
   end

   fjss_core #(
      .ANGLE_WIDTH (ANGLE_WIDTH)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .cfg    (cfg),
      .item   (in_item_ff),
      .result (result)
   );

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (load) begin
         in_item_ff <= req_item;
      end
      if (step) begin
         out_item_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_item_ff.friction_select, out_item_ff.jammed,
                        out_item_ff.aim_ok, out_item_ff.fixed_limit,
                        out_item_ff.drive_enable, out_item_ff.loop_active,
                        out_item_ff.feed_setpoint};

endmodule

### rtl/fjss_csr.sv
// configuration registers of the feeder jam and shot sequencer
// depends on fjss_pkg; also keeps a tenth of the shot increment ready
module fjss_csr
   import fjss_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type     cfg_ff;
   logic [43:0] tenth_prod;

   // reciprocal multiply for the back-off step, taken at write time
   assign tenth_prod = 44'(csr_wdata) * 44'(TENTH_RECIP);

   // register file, reset to the default tuning
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.shot_increment <= 20'd29510;
         cfg_ff.shot_tenth     <= 17'd2951;
         cfg_ff.shot_interval  <= 16'd50;
         cfg_ff.mode_delay     <= 16'd500;
         cfg_ff.stall_speed    <= 15'd5;
         cfg_ff.stall_current  <= 15'd1000;
         cfg_ff.stall_ticks    <= 15'd3000;
         cfg_ff.pitch_window   <= 16'd128;
         cfg_ff.yaw_window     <= 16'd64;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SHOT_INCREMENT: begin
               cfg_ff.shot_increment <= csr_wdata;
               cfg_ff.shot_tenth     <= tenth_prod[TENTH_SHIFT +: TENTH_W];
            end
            CSR_SHOT_INTERVAL: cfg_ff.shot_interval <= csr_wdata[15:0];
            CSR_MODE_DELAY:    cfg_ff.mode_delay    <= csr_wdata[15:0];
            CSR_STALL_SPEED:   cfg_ff.stall_speed   <= csr_wdata[14:0];
            CSR_STALL_CURRENT: cfg_ff.stall_current <= csr_wdata[14:0];
            CSR_STALL_TICKS:   cfg_ff.stall_ticks   <= csr_wdata[14:0];
            CSR_PITCH_WINDOW:  cfg_ff.pitch_window  <= csr_wdata[15:0];
            CSR_YAW_WINDOW:    cfg_ff.yaw_window    <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/fjss_core.sv
// per-tick state update of the feeder jam and shot sequencer
// depends on fjss_pkg; the state advances once per stepped transaction
module fjss_core
   import fjss_pkg::*;
#(
   parameter int ANGLE_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  cfg_type      cfg,
   input  req_item_type item,
   output rsp_item_type result
);

   logic [1:0]             prev_mode_ff, prev_mode_in;
   logic [15:0]            mode_age_ff, mode_age_in;
   logic [14:0]            stall_count_ff, stall_count_in;
   logic                   jam_ff, jam_in;
   logic [15:0]            shot_timer_ff, shot_timer_in;
   logic [ANGLE_WIDTH-1:0] latched_ff, latched_in;
   logic [ANGLE_WIDTH-1:0] held_ff, held_in;

   logic                   delay_over, stalled, aim, run, back_off;
   logic                   drive, fixed;
   logic [1:0]             fric;
   logic [16:0]            speed_mag, current_mag, pitch_mag, yaw_mag;
   logic signed [16:0]     pitch_err, yaw_err;
   logic [15:0]            timer_inc;
   logic [ANGLE_WIDTH-1:0] angle_aw;

   // magnitude of a 17 bit signed value, exact for every input
   function automatic logic [16:0] mag17(input logic signed [16:0] v);
      logic signed [16:0] n;
      n = -v;
      return v[16] ? 17'(n) : 17'(v);
   endfunction

   assign speed_mag   = mag17(17'(item.motor_speed));
   assign current_mag = mag17(17'(item.motor_current));
   assign pitch_err   = 17'(item.pitch_target) - 17'(item.pitch_measured);
   assign yaw_err     = 17'(item.yaw_target) - 17'(item.yaw_measured);
   assign pitch_mag   = mag17(pitch_err);
   assign yaw_mag     = mag17(yaw_err);
   assign angle_aw    = ANGLE_WIDTH'(item.feeder_angle);

   // mode age, stops at the mode delay
   always_comb begin
      prev_mode_in = item.mode;
      if (item.mode != prev_mode_ff) begin
         mode_age_in = '0;
      end else if (mode_age_ff < cfg.mode_delay) begin
         mode_age_in = mode_age_ff + 16'd1;
      end else begin
         mode_age_in = mode_age_ff;
      end
      delay_over = mode_age_in >= cfg.mode_delay;
   end

   // jam counter and flag, clear wins over set
   always_comb begin
      stalled = (speed_mag < 17'(cfg.stall_speed)) && (current_mag > 17'(cfg.stall_current));
      if (stalled) begin
         stall_count_in = (stall_count_ff != '1) ? stall_count_ff + 15'd1 : stall_count_ff;
      end else begin
         stall_count_in = (stall_count_ff != '0) ? stall_count_ff - 15'd1 : stall_count_ff;
      end
      if (stall_count_in == '0) begin
         jam_in = 1'b0;
      end else if (stall_count_in >= cfg.stall_ticks) begin
         jam_in = 1'b1;
      end else begin
         jam_in = jam_ff;
      end
   end

   // aim gate
   assign aim = item.target_locked && (pitch_mag <= 17'(cfg.pitch_window))
                && (yaw_mag <= 17'(cfg.yaw_window));

   // mode decode
   always_comb begin
      run   = 1'b0;
      drive = 1'b0;
      fixed = 1'b0;
      fric  = FRIC_OFF;
      unique case (item.mode)
         MODE_REMOTE: begin
            fric  = FRIC_HIGH;
            run   = 1'b1;
            drive = delay_over;
            fixed = 1'b1;
         end
         MODE_VISION: begin
            fric  = FRIC_HIGH;
            run   = aim;
            drive = aim && delay_over;
         end
         MODE_DEBUG: begin
            fric  = FRIC_TEST;
            run   = 1'b1;
            drive = 1'b1;
         end
         default: ;
      endcase
   end

   // shot timer, position latch and setpoint
   always_comb begin
      timer_inc     = (shot_timer_ff != '1) ? shot_timer_ff + 16'd1 : shot_timer_ff;
      shot_timer_in = shot_timer_ff;
      latched_in    = latched_ff;
      held_in       = held_ff;
      back_off      = (item.mode != MODE_DEBUG) && jam_in;
      if (run) begin
         if (timer_inc >= cfg.shot_interval) begin
            shot_timer_in = '0;
            latched_in    = angle_aw;
         end else begin
            shot_timer_in = timer_inc;
         end
         if (back_off) begin
            held_in = latched_in - ANGLE_WIDTH'(cfg.shot_tenth);
         end else begin
            held_in = latched_in + ANGLE_WIDTH'(cfg.shot_increment);
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_mode_ff   <= MODE_SLEEP;
         mode_age_ff    <= '0;
         stall_count_ff <= '0;
         jam_ff         <= 1'b0;
         shot_timer_ff  <= '0;
         latched_ff     <= '0;
         held_ff        <= '0;
      end else if (step) begin
         prev_mode_ff   <= prev_mode_in;
         mode_age_ff    <= mode_age_in;
         stall_count_ff <= stall_count_in;
         jam_ff         <= jam_in;
         shot_timer_ff  <= shot_timer_in;
         latched_ff     <= latched_in;
         held_ff        <= held_in;
      end
   end

   // result of this tick
   always_comb begin
      result.feed_setpoint   = 32'(signed'(held_in));
      result.loop_active     = run;
      result.drive_enable    = drive;
      result.fixed_limit     = fixed;
      result.aim_ok          = aim;
      result.jammed          = jam_in;
      result.friction_select = fric;
   end

endmodule

### rtl/fjss_checker.sv
// port-level checks of the feeder jam and shot sequencer
// depends on fjss_pkg and assert_macros.svh; bound to the top level below
`include "assert_macros.svh"

module fjss_checker
   import fjss_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready
);

   // a stalled result holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled rsp transaction changed")

   // reset empties the pipeline
   `ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid, "rsp_tvalid high after reset")

   // a fresh result comes from a request accepted into the input register
   `ASSERT_IMPLY(a_rsp_origin, clock, reset, $rose(rsp_tvalid), $past(req_tvalid && req_tready, 2), "rsp transaction without a request")

   // drive and fixed clamp only with the feeder loop running
   `ASSERT_IMPLY(a_loop_gate, clock, reset, rsp_tvalid && !rsp_tdata[32], !rsp_tdata[33] && !rsp_tdata[34], "drive or clamp select without loop")

endmodule

bind feeder_jam_and_shot_sequencer fjss_checker u_fjss_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
